FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Delayed implication: cons holds a fixed number of cycles after ante.
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

FILE: design/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Build-time frame count and the widths derived from it.
// ----------------------------------------------------------------------------
package lru_pkg;

   // Number of frames built into the unit.
   localparam int FRAMES = 8;

   // Width of a frame index and of an age rank.
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   // Width that can hold the value FRAMES itself.
   localparam int OLD_W = $clog2(FRAMES + 1);

   // Width used for the active frame count; covers the 4-bit register too.
   localparam int CNT_W = (OLD_W > 4) ? OLD_W : 4;

   localparam int PAGE_W  = 16;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 32;
   localparam int CSR_W   = 4;

   // Reset value of the frame count register.
   localparam logic [CSR_W-1:0] FRAME_COUNT_RESET = CSR_W'(8);

   typedef logic [IDX_W-1:0]  rank_type;
   typedef logic [PAGE_W-1:0] page_type;

endpackage

FILE: design/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Fully associative page lookup with least recently used replacement.
// ----------------------------------------------------------------------------
// A request accepted at a clock edge passes through the input register, then
// one lookup and update pass into the result register, which drives the result
// strobe. Throughput: one request per cycle; busy is never raised.
// Reset clears the valid bits, ranks and fault counter and sets the frame count
// to 8; the receiver cannot stall results.
`include "assert_macros.svh"

module lru_page_replacement_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lru_pkg::PAGE_W-1:0]    req_page_number,
   input  logic                          csr_write_enable,
   input  logic [lru_pkg::CSR_W-1:0]     csr_write_data,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [lru_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                          rsp_replaced_valid,
   output logic [lru_pkg::PAGE_W-1:0]    rsp_replaced_page,
   output logic [lru_pkg::COUNT_W-1:0]   rsp_fault_count
);
   import lru_pkg::*;

   // Configuration register.
   logic [CSR_W-1:0]   frame_count_ff;

   // Input register.
   logic               req_valid_ff;
   page_type           req_page_ff;

   // Frame state.
   page_type           page_tag_ff   [FRAMES];
   logic [FRAMES-1:0]  frame_valid_ff;
   logic [FRAMES-1:0]  frame_valid_in;
   rank_type           age_rank_ff   [FRAMES];
   rank_type           age_rank_in   [FRAMES];
   logic [COUNT_W-1:0] fault_total_ff;
   logic [COUNT_W-1:0] fault_total_in;

   // Result register.
   logic               rsp_strobe_ff;
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_replaced_valid_ff;
   page_type           rsp_replaced_page_ff;
   logic [COUNT_W-1:0] rsp_fault_count_ff;

   // Lookup signals.
   logic [CNT_W-1:0]   active_num;
   logic [FRAMES-1:0]  active;
   logic               hit;
   logic               empty_found;
   logic               evict;
   logic [IDX_W-1:0]   sel;
   rank_type           best_rank;
   logic [OLD_W-1:0]   old_rank;
   page_type           victim;
   logic [IDX_W+SLOT_W-1:0] sel_ext;

   // The receiver cannot stall, so every request passes straight through.
   assign busy = 1'b0;

   // Frame count register; the user must write it only while the unit is idle (the block itself does not enforce this).
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
      end else if (csr_write_enable) begin
         frame_count_ff <= csr_write_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      if (start && !busy) begin
         req_page_ff <= req_page_number;
      end
   end

   // Lookup, choice of frame and recency update.
   always_comb begin
      active_num = CNT_W'(frame_count_ff);
      if (active_num == '0) begin
         active_num = CNT_W'(1);
      end
      if (active_num > CNT_W'(FRAMES)) begin
         active_num = CNT_W'(FRAMES);
      end
      for (int f = 0; f < FRAMES; f++) begin
         active[f] = CNT_W'(f) < active_num;
      end

      // Lowest-numbered active frame holding the page.
      hit = 1'b0;
      sel = '0;
      for (int f = 0; f < FRAMES; f++) begin
         if (!hit && active[f] && frame_valid_ff[f] && page_tag_ff[f] == req_page_ff) begin
            hit = 1'b1;
            sel = IDX_W'(f);
         end
      end

      // On a miss, the lowest-numbered empty active frame.
      empty_found = 1'b0;
      if (!hit) begin
         for (int f = 0; f < FRAMES; f++) begin
            if (!empty_found && active[f] && !frame_valid_ff[f]) begin
               empty_found = 1'b1;
               sel = IDX_W'(f);
            end
         end
      end

      // Otherwise the oldest active frame; later frames win ties.
      evict = !hit && !empty_found;
      best_rank = '0;
      if (evict) begin
         for (int f = 0; f < FRAMES; f++) begin
            if (active[f] && age_rank_ff[f] >= best_rank) begin
               best_rank = age_rank_ff[f];
               sel = IDX_W'(f);
            end
         end
      end
      victim = evict ? page_tag_ff[sel] : '0;

      // Saturating fault counter.
      fault_total_in = fault_total_ff;
      if (!hit && fault_total_ff != '1) begin
         fault_total_in = fault_total_ff + COUNT_W'(1);
      end

      // Frames younger than the chosen one age by one; it becomes rank zero.
      old_rank = frame_valid_ff[sel] ? OLD_W'(age_rank_ff[sel]) : OLD_W'(FRAMES);
      frame_valid_in = frame_valid_ff;
      for (int f = 0; f < FRAMES; f++) begin
         age_rank_in[f] = age_rank_ff[f];
         if (IDX_W'(f) != sel && frame_valid_ff[f] && OLD_W'(age_rank_ff[f]) < old_rank) begin
            age_rank_in[f] = age_rank_ff[f] + IDX_W'(1);
         end
      end
      age_rank_in[sel] = '0;
      frame_valid_in[sel] = 1'b1;

      sel_ext = {{SLOT_W{1'b0}}, sel};
   end

   // Frame state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         fault_total_ff <= '0;
         for (int f = 0; f < FRAMES; f++) begin
            age_rank_ff[f] <= '0;
         end
      end else if (req_valid_ff) begin
         frame_valid_ff <= frame_valid_in;
         fault_total_ff <= fault_total_in;
         for (int f = 0; f < FRAMES; f++) begin
            age_rank_ff[f] <= age_rank_in[f];
         end
      end
   end

   // Tag store: a miss writes the page into the chosen frame.
   always_ff @(posedge clock) begin
      if (req_valid_ff && !hit) begin
         page_tag_ff[sel] <= req_page_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_hit_ff            <= hit;
         rsp_slot_ff           <= sel_ext[SLOT_W-1:0];
         rsp_replaced_valid_ff <= evict;
         rsp_replaced_page_ff  <= victim;
         rsp_fault_count_ff    <= fault_total_in;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_replaced_valid = rsp_replaced_valid_ff;
   assign rsp_replaced_page  = rsp_replaced_page_ff;
   assign rsp_fault_count    = rsp_fault_count_ff;

   // Checks on the lookup and the result timing.
   `ASSERT_DELAY(a_result_follows, clock, reset, start && !busy, 2, rsp_strobe, "request lost")
   `ASSERT_IMPLY(a_hit_no_evict, clock, reset, rsp_strobe && rsp_hit, !rsp_replaced_valid, "hit evicted a page")
   `ASSERT_IMPLY(a_victim_zero, clock, reset, rsp_strobe && !rsp_replaced_valid, rsp_replaced_page == '0, "victim page without eviction")
   `ASSERT_IMPLY(a_chosen_valid, clock, reset, req_valid_ff, frame_valid_in[sel], "chosen frame not marked valid")

endmodule
